// ----- hw/rtl/lr_pkg.sv -----
// shared types and constants of the line rasterizer
package lr_pkg;

  // field widths of the request channels
  localparam int CoordBits    = 12;
  localparam int ColourBits   = 32;
  // decision term spans [-2*major, 2*minor]
  localparam int DecBits      = CoordBits + 2;
  // default depth of the command queue between front and back
  localparam int CmdFifoDepth = 2;

  typedef enum logic [0:0] {
    OpStart   = 1'b0,
    OpAdvance = 1'b1
  } op_e;

  // input request
  typedef struct packed {
    op_e                   operation;
    logic [CoordBits-1:0]  start_x;
    logic [CoordBits-1:0]  start_y;
    logic [CoordBits-1:0]  end_x;
    logic [CoordBits-1:0]  end_y;
    logic [ColourBits-1:0] pixel_colour;
  } in_req_t;

  // output request
  typedef struct packed {
    logic [CoordBits-1:0]  pixel_x;
    logic [CoordBits-1:0]  pixel_y;
    logic [ColourBits-1:0] pixel_value;
    logic                  last_pixel;
  } out_req_t;

  // classified command handed from front to back
  typedef struct packed {
    op_e                   operation;
    logic [CoordBits-1:0]  start_x;
    logic [CoordBits-1:0]  start_y;
    logic                  step_x_negative;
    logic                  step_y_negative;
    logic                  steep_flag;
    logic [CoordBits-1:0]  delta_major;
    logic [CoordBits-1:0]  delta_minor;
    logic [DecBits-1:0]    decision_term;
    logic [ColourBits-1:0] colour;
  } cmd_t;

  // queue status seen by the back end
  typedef struct packed {
    logic valid;
    logic full;
  } fifo_status_t;

endpackage

// ----- hw/rtl/lr_front.sv -----
// front end: classifies requests and sets up line parameters
module lr_front
  import lr_pkg::*;
(
  input  in_req_t req_i,
  output cmd_t    cmd_o
);

  logic signed [CoordBits:0] dx;
  logic signed [CoordBits:0] dy;
  logic [CoordBits:0]        abs_dx;
  logic [CoordBits:0]        abs_dy;
  logic [CoordBits-1:0]      span_x;
  logic [CoordBits-1:0]      span_y;
  logic                      steep;
  logic [CoordBits-1:0]      major;
  logic [CoordBits-1:0]      minor;

  // signed spans and their magnitudes
  always_comb begin
    dx     = $signed({1'b0, req_i.end_x}) - $signed({1'b0, req_i.start_x});
    dy     = $signed({1'b0, req_i.end_y}) - $signed({1'b0, req_i.start_y});
    abs_dx = dx[CoordBits] ? (~dx + 1'b1) : dx;
    abs_dy = dy[CoordBits] ? (~dy + 1'b1) : dy;
    span_x = abs_dx[CoordBits-1:0];
    span_y = abs_dy[CoordBits-1:0];
    steep  = span_y > span_x;
    major  = steep ? span_y : span_x;
    minor  = steep ? span_x : span_y;
  end

  // command toward the back end
  always_comb begin
    cmd_o.operation       = req_i.operation;
    cmd_o.start_x         = req_i.start_x;
    cmd_o.start_y         = req_i.start_y;
    cmd_o.step_x_negative = dx[CoordBits];
    cmd_o.step_y_negative = dy[CoordBits];
    cmd_o.steep_flag      = steep;
    cmd_o.delta_major     = major;
    cmd_o.delta_minor     = minor;
    cmd_o.decision_term   = {1'b0, minor, 1'b0} - {2'b00, major};
    cmd_o.colour          = req_i.pixel_colour;
  end

endmodule

// ----- hw/rtl/lr_cmd_fifo.sv -----
// command queue between front and back ends
module lr_cmd_fifo
  import lr_pkg::*;
#(
  parameter int DEPTH = CmdFifoDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  cmd_t                       data_i,
  input  logic                       pop_i,
  output cmd_t                       data_o,
  output fifo_status_t               status_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntBits = $clog2(DEPTH + 1);

  cmd_t               mem_q [DEPTH];
  logic [PtrBits-1:0] wptr_q, wptr_d;
  logic [PtrBits-1:0] rptr_q, rptr_d;
  logic [CntBits-1:0] count_q, count_d;
  logic               do_push;
  logic               do_pop;

  assign status_o.valid = count_q != '0;
  assign status_o.full  = count_q == CntBits'(DEPTH);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && status_o.valid;
  assign data_o         = mem_q[rptr_q];
  assign count_o        = count_q;

  // pointer and fill count update
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrBits'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrBits'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// ----- hw/rtl/lr_back.sv -----
// back end: walks the loaded line and holds the output request
module lr_back
  import lr_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cmd_t         cmd_i,
  input  fifo_status_t status_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output out_req_t     out_req_o
);

  // line state
  logic [CoordBits-1:0]  cur_x_q, cur_x_d;
  logic [CoordBits-1:0]  cur_y_q, cur_y_d;
  logic [DecBits-1:0]    dec_q, dec_d;
  logic [CoordBits-1:0]  major_q, major_d;
  logic [CoordBits-1:0]  minor_q, minor_d;
  logic [CoordBits-1:0]  steps_q, steps_d;
  logic                  xneg_q, xneg_d;
  logic                  yneg_q, yneg_d;
  logic                  steep_q, steep_d;
  logic                  active_q, active_d;
  logic [ColourBits-1:0] colour_q, colour_d;

  // output register
  logic                  out_valid_q, out_valid_d;
  out_req_t              out_q, out_d;

  logic                  minor_step;
  logic [CoordBits-1:0]  x_walk;
  logic [CoordBits-1:0]  y_walk;
  logic                  emit;
  logic                  last;

  // take a command whenever the output register is free or draining
  assign pop_o = status_i.valid && (!out_valid_q || out_ready_i);

  assign minor_step = !dec_q[DecBits-1] && (dec_q != '0);
  assign x_walk     = xneg_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
  assign y_walk     = yneg_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;

  // command execution
  always_comb begin
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    dec_d    = dec_q;
    major_d  = major_q;
    minor_d  = minor_q;
    steps_d  = steps_q;
    xneg_d   = xneg_q;
    yneg_d   = yneg_q;
    steep_d  = steep_q;
    active_d = active_q;
    colour_d = colour_q;
    emit     = 1'b0;
    last     = 1'b0;
    if (pop_o) begin
      unique case (cmd_i.operation)
        OpStart: begin
          cur_x_d  = cmd_i.start_x;
          cur_y_d  = cmd_i.start_y;
          dec_d    = cmd_i.decision_term;
          major_d  = cmd_i.delta_major;
          minor_d  = cmd_i.delta_minor;
          steps_d  = cmd_i.delta_major;
          xneg_d   = cmd_i.step_x_negative;
          yneg_d   = cmd_i.step_y_negative;
          steep_d  = cmd_i.steep_flag;
          colour_d = cmd_i.colour;
          active_d = cmd_i.delta_major != '0;
          emit     = cmd_i.delta_major != '0;
        end
        OpAdvance: begin
          if (active_q) begin
            if (steep_q) begin
              cur_y_d = y_walk;
              if (minor_step) cur_x_d = x_walk;
            end else begin
              cur_x_d = x_walk;
              if (minor_step) cur_y_d = y_walk;
            end
            if (minor_step) begin
              dec_d = dec_q + {1'b0, minor_q, 1'b0} - {1'b0, major_q, 1'b0};
            end else begin
              dec_d = dec_q + {1'b0, minor_q, 1'b0};
            end
            steps_d = steps_q - 1'b1;
            last    = steps_q == CoordBits'(1);
            if (last) begin
              steps_d  = '0;
              active_d = 1'b0;
            end
            emit = 1'b1;
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  // output request next value
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (emit) begin
      out_valid_d       = 1'b1;
      out_d.pixel_x     = cur_x_d;
      out_d.pixel_y     = cur_y_d;
      out_d.pixel_value = colour_d;
      out_d.last_pixel  = last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_x_q  <= cur_x_d;
    cur_y_q  <= cur_y_d;
    dec_q    <= dec_d;
    major_q  <= major_d;
    minor_q  <= minor_d;
    steps_q  <= steps_d;
    xneg_q   <= xneg_d;
    yneg_q   <= yneg_d;
    steep_q  <= steep_d;
    colour_q <= colour_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

// ----- hw/rtl/line_rasterizer_core.sv -----
// top level of the midpoint line rasterizer
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o   in_req_i  (start or advance)
//   out      output     out_valid_o / out_ready_i out_req_o (one pixel)
//
// One request is accepted per cycle while the queue is not full; a request is written
// into the command queue, popped from its head by the back end, and its pixel is
// registered in the back end's output register.
// Sustained rate is one pixel per clock while out_ready_i stays high, set by the
// back end's decision update taking one step per advance command.
// Reset clears the queue, the output valid flag and the active-line flag.
// An output stall fills the FIFO_DEPTH-entry queue, then drops in_ready_o.
module line_rasterizer_core
  import lr_pkg::*;
#(
  parameter int FIFO_DEPTH = CmdFifoDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_req_t out_req_o
);

  localparam int CntBits = $clog2(FIFO_DEPTH + 1);

  cmd_t               front_cmd;
  cmd_t               head_cmd;
  fifo_status_t       fifo_status;
  logic               pop;
  logic [CntBits-1:0] fifo_count;

  assign in_ready_o = !fifo_status.full;

  lr_front u_front (
    .req_i (in_req_i),
    .cmd_o (front_cmd)
  );

  lr_cmd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (in_valid_i),
    .data_i   (front_cmd),
    .pop_i    (pop),
    .data_o   (head_cmd),
    .status_o (fifo_status),
    .count_o  (fifo_count)
  );

  lr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (head_cmd),
    .status_i    (fifo_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o)
  );

  // queue never overfills
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_count <= CntBits'(FIFO_DEPTH))
    else $error("command queue over capacity");

  // no command is taken while a pixel is stuck at the output
  a_no_pop_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !pop)
    else $error("command popped during output stall");

  // a pop with nothing pushed lowers the fill count by one
  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !(in_valid_i && in_ready_o)) |=> (fifo_count == $past(fifo_count) - 1'b1))
    else $error("fill count wrong after pop");

endmodule

// ----- tb/tb.sv -----
// testbench for the midpoint line rasterizer core
`timescale 1ns / 1ps

module tb;
  import lr_pkg::*;

  localparam int StallLimit   = 5000;
  localparam int TargetPixels = 1600;
  localparam int CoordMax     = (1 << CoordBits) - 1;

  logic     clk_i;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  in_req_t  in_req = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_req_t out_req;

  line_rasterizer_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_req_o  (out_req)
  );

  // requests waiting to be sent and pixels waiting to come out
  in_req_t  queued_requests[$];
  out_req_t pending_pixels[$];

  int total_requests    = 0;
  int requests_accepted = 0;
  int lines_started     = 0;
  int pixels_checked    = 0;
  int line_ends_seen    = 0;
  int mismatches        = 0;
  int stall_cycles      = 0;
  int send_idle_pct;
  int recv_idle_pct;

  // shadow copy of the rasterizer state
  logic [CoordBits-1:0]  pos_x;
  logic [CoordBits-1:0]  pos_y;
  logic [ColourBits-1:0] line_colour;
  int                    dec_term;
  int                    span_major;
  int                    span_minor;
  int                    steps_rem;
  bit                    neg_x;
  bit                    neg_y;
  bit                    steep;
  bit                    active;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [CoordBits-1:0] step_coord(logic [CoordBits-1:0] c, bit down);
    return down ? c - 1'b1 : c + 1'b1;
  endfunction

  // walk the line one request at a time and queue the pixel it yields
  function automatic void rasterize_request(in_req_t req);
    int dx;
    int dy;
    bit minor_step;
    if (req.operation == OpStart) begin
      dx = int'(req.end_x) - int'(req.start_x);
      dy = int'(req.end_y) - int'(req.start_y);
      neg_x = dx < 0;
      neg_y = dy < 0;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      steep = dy > dx;
      span_major = steep ? dy : dx;
      span_minor = steep ? dx : dy;
      steps_rem = span_major;
      dec_term = 2 * span_minor - span_major;
      pos_x = req.start_x;
      pos_y = req.start_y;
      line_colour = req.pixel_colour;
      active = span_major != 0;
      if (active) begin
        lines_started++;
        pending_pixels.push_back('{pixel_x: pos_x, pixel_y: pos_y,
                                   pixel_value: line_colour, last_pixel: 1'b0});
      end
    end else if (active) begin
      minor_step = dec_term > 0;
      if (steep) begin
        pos_y = step_coord(pos_y, neg_y);
        if (minor_step) pos_x = step_coord(pos_x, neg_x);
      end else begin
        pos_x = step_coord(pos_x, neg_x);
        if (minor_step) pos_y = step_coord(pos_y, neg_y);
      end
      dec_term += minor_step ? 2 * (span_minor - span_major) : 2 * span_minor;
      steps_rem--;
      if (steps_rem <= 0) begin
        steps_rem = 0;
        active = 1'b0;
      end
      pending_pixels.push_back('{pixel_x: pos_x, pixel_y: pos_y,
                                 pixel_value: line_colour, last_pixel: !active});
    end
  endfunction

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      mismatches++;
    end
  endtask

  task automatic push_request(op_e op, int sx, int sy, int ex, int ey,
                              logic [ColourBits-1:0] colour);
    in_req_t req;
    req.operation    = op;
    req.start_x      = CoordBits'(sx);
    req.start_y      = CoordBits'(sy);
    req.end_x        = CoordBits'(ex);
    req.end_y        = CoordBits'(ey);
    req.pixel_colour = colour;
    queued_requests.push_back(req);
  endtask

  task automatic push_advance();
    push_request(OpAdvance, int'($urandom), int'($urandom),
                 int'($urandom), int'($urandom), $urandom);
  endtask

  // idling profile follows progress through the request stream
  always_comb begin
    if (requests_accepted < total_requests / 3) begin
      send_idle_pct = 32;
      recv_idle_pct = 68;
    end else if (requests_accepted < 2 * total_requests / 3) begin
      send_idle_pct = 68;
      recv_idle_pct = 32;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  end

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_req   <= '0;
    end else begin
      if (in_valid && in_ready) begin
        rasterize_request(in_req);
        requests_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (queued_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_req   <= queued_requests.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // pixel monitor
  always @(posedge clk_i or negedge rst_ni) begin
    out_req_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_pixels.size() == 0) begin
          $display("%0t: unexpected pixel, expected none, actual x=%0d y=%0d v=%0h last=%0b",
                   $time, out_req.pixel_x, out_req.pixel_y, out_req.pixel_value,
                   out_req.last_pixel);
          mismatches++;
        end else begin
          want = pending_pixels.pop_front();
          check_field("pixel_x", 32'(want.pixel_x), 32'(out_req.pixel_x));
          check_field("pixel_y", 32'(want.pixel_y), 32'(out_req.pixel_y));
          check_field("pixel_value", want.pixel_value, out_req.pixel_value);
          check_field("last_pixel", 32'(want.last_pixel), 32'(out_req.last_pixel));
          pixels_checked++;
          if (want.last_pixel) line_ends_seen++;
        end
      end
      out_ready <= $urandom_range(0, 99) >= recv_idle_pct;
    end
  end

  // cycles with no progress on either channel
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    while (stall_cycles < StallLimit) @(posedge clk_i);
    $display("%0t: no progress for %0d cycles", $time, StallLimit);
    $display("Regression FAIL");
    $finish;
  end

  // stimulus and end of run
  initial begin
    int planned;
    int line_left;
    int dx;
    int dy;
    int sx;
    int sy;
    int ex;
    int ey;
    int len;
    int advs;
    int span;
    int pick;

    // directed: idle advance, zero length, extremes, restart, octants, tie
    push_request(OpAdvance, '1, '1, '1, '1, '1);
    push_request(OpStart, 100, 100, 100, 100, 32'h1234_5678);
    push_request(OpAdvance, 0, 0, 0, 0, 0);
    push_request(OpStart, 0, 0, CoordMax, CoordMax, '1);
    push_advance();
    push_advance();
    push_request(OpStart, CoordMax, 0, CoordMax - 2, CoordMax, '0);
    push_advance();
    push_advance();
    push_request(OpStart, CoordMax, CoordMax, CoordMax - 3, CoordMax - 1, 32'ha5a5_a5a5);
    repeat (4) push_advance();
    push_request(OpStart, 0, CoordMax, 1, CoordMax - 3, 32'h5a5a_5a5a);
    repeat (3) push_advance();
    push_request(OpStart, 10, 10, 12, 11, 32'h0f0f_0f0f);
    push_advance();
    push_advance();

    // random: mostly complete short lines, some long or cut short, some noise
    planned   = 0;
    line_left = 0;
    while (planned < TargetPixels) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        span = ($urandom_range(0, 19) == 0) ? CoordMax : 12;
        sx = $urandom_range(0, CoordMax);
        sy = $urandom_range(0, CoordMax);
        dx = $urandom_range(0, span);
        dy = $urandom_range(0, span);
        if ($urandom_range(0, 1)) dx = -dx;
        if ($urandom_range(0, 1)) dy = -dy;
        if (sx + dx > CoordMax || sx + dx < 0) dx = -dx;
        if (sy + dy > CoordMax || sy + dy < 0) dy = -dy;
        ex = sx + dx;
        ey = sy + dy;
        if (ex > CoordMax) ex = CoordMax;
        if (ex < 0) ex = 0;
        if (ey > CoordMax) ey = CoordMax;
        if (ey < 0) ey = 0;
        len = (ex > sx) ? ex - sx : sx - ex;
        if (((ey > sy) ? ey - sy : sy - ey) > len) len = (ey > sy) ? ey - sy : sy - ey;
        pick = $urandom_range(0, 99);
        if (len > 24) advs = $urandom_range(1, 16);
        else if (pick < 75) advs = len;
        else if (pick < 85) advs = len + $urandom_range(1, 2);
        else advs = $urandom_range(0, len);
        push_request(OpStart, sx, sy, ex, ey, $urandom);
        repeat (advs) push_advance();
        planned += (len > 0) + ((advs < len) ? advs : len);
        line_left = (advs < len) ? len - advs : 0;
      end else if (pick < 92) begin
        push_advance();
        if (line_left > 0) begin
          planned++;
          line_left--;
        end
      end else begin
        sx = $urandom_range(0, CoordMax);
        sy = $urandom_range(0, CoordMax);
        push_request(OpStart, sx, sy, sx, sy, $urandom);
        line_left = 0;
      end
    end
    total_requests = queued_requests.size();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (queued_requests.size() != 0 || in_valid || pending_pixels.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("sent %0d requests in three idling phases: %0d lines drawn", requests_accepted,
             lines_started);
    $display("checked %0d pixels, %0d of them line ends", pixels_checked, line_ends_seen);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
